// ===== hw/rtl/itc_pkg.sv =====
// Shared types, constants and command codes for the interval timer.
`timescale 1ns / 1ps
`default_nettype none

package itc_pkg;

  // Time, counter and interval widths
  localparam int TIME_BITS  = 48;
  localparam int COUNT_BITS = 16;
  localparam int IV_BITS    = 32;
  localparam int STEP_W     = $clog2(TIME_BITS);

  localparam logic [IV_BITS-1:0]    INTERVAL_RST = IV_BITS'(1000);
  localparam logic [COUNT_BITS-1:0] CNT_MAX      = '1;
  localparam logic [STEP_W-1:0]     STEP_LAST    = STEP_W'(TIME_BITS - 1);

  // Command codes carried by the action field
  localparam logic [2:0] ACT_START    = 3'd0;
  localparam logic [2:0] ACT_ONESHOT  = 3'd1;
  localparam logic [2:0] ACT_ALIGN    = 3'd2;
  localparam logic [2:0] ACT_AT       = 3'd3;
  localparam logic [2:0] ACT_STOP     = 3'd4;
  localparam logic [2:0] ACT_UPDATE   = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } itc_state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic div_load;
    logic div_step;
    logic commit;
  } itc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;
  } itc_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/interval_timer_catchup.sv =====
// Top level of the millisecond interval timer with catch-up reporting.
//
// Usage: each input item is a command (in_action) with the current time
// (in_now_ms) and a reference time (in_ref_time_ms), sent on a valid/stall
// channel. Every command returns exactly one result item on the out_ channel:
// elapsed flag, saturating fire count, first and last due times, running flag
// and the deadline left armed. The period is written through cfg_wr_en /
// cfg_interval_ms while no command is in flight; it resets to 1000 ms.
// Timing: one command at a time. A command without division passes through the
// load, finish and output states after accept. An aligned start whose reference
// is not after now, or a periodic update that found the deadline reached, also
// runs a 48-step restoring divider between load and finish, one quotient bit per
// cycle. The next command is taken the cycle after the result is taken.
// in_stall is high from accept until the result leaves; a stalled result holds
// its value. Synchronous active-low reset stops the timer, clears the deadline
// and empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none

module interval_timer_catchup (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [itc_pkg::IV_BITS-1:0]   cfg_interval_ms,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [2:0]                    in_action,
  input  wire logic [itc_pkg::TIME_BITS-1:0] in_now_ms,
  input  wire logic [itc_pkg::TIME_BITS-1:0] in_ref_time_ms,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_elapsed,
  output logic [itc_pkg::COUNT_BITS-1:0]     out_fire_count,
  output logic [itc_pkg::TIME_BITS-1:0]      out_first_due_ms,
  output logic [itc_pkg::TIME_BITS-1:0]      out_last_due_ms,
  output logic                               out_running,
  output logic [itc_pkg::TIME_BITS-1:0]      out_next_deadline_ms
);
  import itc_pkg::*;

  itc_cmd_t cmd;
  itc_sts_t sts;

  // Sequencer
  itc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath
  itc_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_interval_ms      (cfg_interval_ms),
    .in_action            (in_action),
    .in_now_ms            (in_now_ms),
    .in_ref_time_ms       (in_ref_time_ms),
    .out_elapsed          (out_elapsed),
    .out_fire_count       (out_fire_count),
    .out_first_due_ms     (out_first_due_ms),
    .out_last_due_ms      (out_last_due_ms),
    .out_running          (out_running),
    .out_next_deadline_ms (out_next_deadline_ms)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/itc_ctrl.sv =====
// Sequencer for the interval timer: accept, divide, commit, deliver.
`timescale 1ns / 1ps
`default_nettype none

module itc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  input  wire itc_pkg::itc_sts_t sts,
  output itc_pkg::itc_cmd_t    cmd
);
  import itc_pkg::*;

  itc_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  // Advance state and divider step count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        step_nxt  = '0;
        state_nxt = sts.need_div ? ST_DIV : ST_FIN;
      end
      ST_DIV: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_LAST) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_LOAD: cmd.div_load = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_FIN:  cmd.commit   = 1'b1;
      ST_OUT:  out_valid    = 1'b1;
      default: ;
    endcase
  end

  // A result is never offered while an item can be taken
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("result shown while input open");

  // A commit is delivered in the next cycle
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid) else $error("commit not followed by result");

  // An accepted item starts the load step
  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_LOAD)) else $error("accept lost");

  // Divider runs exactly one step per quotient bit
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && $past(state_r) == ST_DIV) |-> ($past(step_r) == STEP_LAST))
    else $error("divider step count wrong");

  // A delivered result frees the block
  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |=> !out_valid) else $error("result repeated");

endmodule

`default_nettype wire

// ===== hw/rtl/itc_dp.sv =====
// Timer datapath: command registers, serial divider, timer state and results.
`timescale 1ns / 1ps
`default_nettype none

module itc_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire itc_pkg::itc_cmd_t             cmd,
  output itc_pkg::itc_sts_t                  sts,
  input  wire logic                          cfg_wr_en,
  input  wire logic [itc_pkg::IV_BITS-1:0]   cfg_interval_ms,
  input  wire logic [2:0]                    in_action,
  input  wire logic [itc_pkg::TIME_BITS-1:0] in_now_ms,
  input  wire logic [itc_pkg::TIME_BITS-1:0] in_ref_time_ms,
  output logic                               out_elapsed,
  output logic [itc_pkg::COUNT_BITS-1:0]     out_fire_count,
  output logic [itc_pkg::TIME_BITS-1:0]      out_first_due_ms,
  output logic [itc_pkg::TIME_BITS-1:0]      out_last_due_ms,
  output logic                               out_running,
  output logic [itc_pkg::TIME_BITS-1:0]      out_next_deadline_ms
);
  import itc_pkg::*;

  logic [IV_BITS-1:0]    interval_r;
  logic [2:0]            act_r;
  logic [TIME_BITS-1:0]  now_r, ref_r;
  logic                  active_r, one_shot_r;
  logic [TIME_BITS-1:0]  deadline_r;
  logic [TIME_BITS-1:0]  quo_r;
  logic [IV_BITS-1:0]    rem_r;

  logic [IV_BITS-1:0]    iv;
  logic [TIME_BITS-1:0]  iv_ext, rem_ext;
  logic [IV_BITS:0]      trial, diff;
  logic                  fits;
  logic                  due;

  logic                  active_nxt, one_shot_nxt;
  logic [TIME_BITS-1:0]  deadline_nxt;
  logic                  elapsed_nxt;
  logic [COUNT_BITS-1:0] count_nxt;
  logic [TIME_BITS-1:0]  first_nxt, last_nxt;

  // Zero interval counts as one
  assign iv      = (interval_r == '0) ? IV_BITS'(1) : interval_r;
  assign iv_ext  = {{(TIME_BITS-IV_BITS){1'b0}}, iv};
  assign rem_ext = {{(TIME_BITS-IV_BITS){1'b0}}, rem_r};
  assign due     = active_r && (now_r >= deadline_r);

  // Division needed for aligned start not in the future and periodic catch-up
  assign sts.need_div = ((act_r == ACT_ALIGN) && (ref_r <= now_r)) ||
                        ((act_r == ACT_UPDATE) && due && !one_shot_r);

  // Restoring divider step
  assign trial = {rem_r, quo_r[TIME_BITS-1]};
  assign diff  = trial - {1'b0, iv};
  assign fits  = (trial >= {1'b0, iv});

  // Hold the period register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= INTERVAL_RST;
    end else if (cfg_wr_en) begin
      interval_r <= cfg_interval_ms;
    end
  end

  // Capture the command item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= in_action;
      now_r <= in_now_ms;
      ref_r <= in_ref_time_ms;
    end
  end

  // Load and shift the divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      quo_r <= (act_r == ACT_ALIGN) ? (now_r - ref_r) : (now_r - deadline_r);
      rem_r <= '0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[TIME_BITS-2:0], fits};
      rem_r <= fits ? diff[IV_BITS-1:0] : trial[IV_BITS-1:0];
    end
  end

  // Work out the new timer state and the result
  always_comb begin
    active_nxt   = active_r;
    one_shot_nxt = one_shot_r;
    deadline_nxt = deadline_r;
    elapsed_nxt  = 1'b0;
    count_nxt    = '0;
    first_nxt    = '0;
    last_nxt     = '0;
    unique case (act_r)
      ACT_START, ACT_ONESHOT: begin
        active_nxt   = 1'b1;
        one_shot_nxt = (act_r == ACT_ONESHOT);
        deadline_nxt = now_r + iv_ext;
      end
      ACT_ALIGN: begin
        active_nxt   = 1'b1;
        one_shot_nxt = 1'b0;
        // Next grid point after now is now minus remainder plus one period
        deadline_nxt = (ref_r > now_r) ? ref_r : (now_r - rem_ext + iv_ext);
      end
      ACT_AT: begin
        one_shot_nxt = 1'b1;
        active_nxt   = (ref_r >= now_r);
        deadline_nxt = (ref_r >= now_r) ? ref_r : '0;
      end
      ACT_STOP: begin
        active_nxt   = 1'b0;
        deadline_nxt = '0;
      end
      ACT_UPDATE: begin
        if (due) begin
          elapsed_nxt = 1'b1;
          first_nxt   = deadline_r;
          if (one_shot_r) begin
            count_nxt    = COUNT_BITS'(1);
            last_nxt     = deadline_r;
            active_nxt   = 1'b0;
            deadline_nxt = '0;
          end else begin
            if (quo_r >= {{(TIME_BITS-COUNT_BITS){1'b0}}, CNT_MAX}) begin
              count_nxt = CNT_MAX;
            end else begin
              count_nxt = quo_r[COUNT_BITS-1:0] + 1'b1;
            end
            // Last due time is deadline plus whole periods, i.e. now less remainder
            last_nxt     = now_r - rem_ext;
            deadline_nxt = now_r - rem_ext + iv_ext;
          end
        end
      end
      default: ;
    endcase
  end

  // Commit timer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      one_shot_r <= 1'b0;
      deadline_r <= '0;
    end else if (cmd.commit) begin
      active_r   <= active_nxt;
      one_shot_r <= one_shot_nxt;
      deadline_r <= deadline_nxt;
    end
  end

  // Register the result item
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_elapsed          <= elapsed_nxt;
      out_fire_count       <= count_nxt;
      out_first_due_ms     <= first_nxt;
      out_last_due_ms      <= last_nxt;
      out_running          <= active_nxt;
      out_next_deadline_ms <= active_nxt ? deadline_nxt : '0;
    end
  end

endmodule

`default_nettype wire
